@@ rtl/sjrq_pkg.sv @@
// Package for the shortest-job ready queue.
// Holds depth constants, item structs, opcode and status codes.
// Used by sjrq_cell and shortest_job_ready_queue_core.
package sjrq_pkg;

    // Number of cells in the chain, and the widths that follow from it.
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int ID_W        = 16;
    localparam int KEY_W       = 16;
    localparam int OCC_W       = 5;

    // Opcode values of an input item.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // One input item.
    typedef struct packed {
        logic             opcode;
        logic [ID_W-1:0]  job_id;
        logic [KEY_W-1:0] burst_time;
    } t_in_item;

    // One result item.
    typedef struct packed {
        logic             out_valid;
        logic [ID_W-1:0]  out_job_id;
        logic [KEY_W-1:0] out_burst_time;
        logic [1:0]       status;
        logic [OCC_W-1:0] occupancy;
    } t_out_item;

    // One queue entry as held in a cell.
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [KEY_W-1:0] key;
    } t_entry;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic   do_insert;
        logic   do_remove;
        t_entry new_entry;
    } t_cell_ctl;

endpackage

@@ rtl/sjrq_cell.sv @@
// One cell of the sorted chain: holds a single entry.
// Depends on sjrq_pkg for the entry and control structs.
module sjrq_cell
    import sjrq_pkg::*;
(
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  logic      i_occupied,
    input  t_entry    i_left_entry,
    input  logic      i_left_keep,
    input  t_entry    i_right_entry,
    output t_entry    o_entry,
    output logic      o_keep
);

    t_entry r_entry;
    t_entry n_entry;

    // The cell keeps its entry on insert when it holds a key not above the new one.
    assign o_keep = i_occupied && (r_entry.key <= i_ctl.new_entry.key);

    // Insert shifts the tail right by one; remove shifts everything left.
    always_comb begin
        n_entry = r_entry;
        if (i_ctl.do_insert) begin
            if (o_keep) begin
                n_entry = r_entry;
            end else if (i_left_keep) begin
                n_entry = i_ctl.new_entry;
            end else begin
                n_entry = i_left_entry;
            end
        end else if (i_ctl.do_remove) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

@@ rtl/shortest_job_ready_queue_core.sv @@
// Top level of the shortest-job ready queue: a chain of sjrq_cell cells
// plus the entry counter and the registered result. Depends on sjrq_pkg.
//
// Usage:
// An item is presented on i_in with i_start high; it is accepted at any
// rising edge where i_start is high and o_busy is low. o_busy is always
// low, so one item is accepted every cycle. An insert item places its job
// behind every held job whose burst time is less than or equal to its own;
// a remove item takes the head job out of the queue.
// Each item gives one result on o_out, marked by o_done, in the cycle right
// after acceptance (throughput one item per cycle). The cells compare their
// keys against the new key and shift in the same cycle, so the next item
// already sees the updated order.
// A refused insert (full) or remove (empty) leaves the queue unchanged and
// reports it in the status field.
// Reset empties the queue by clearing the entry count; cell contents are
// left as they are and are never read before being written.
// The receiver cannot stall: a result is shown for exactly one cycle.
module shortest_job_ready_queue_core
    import sjrq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_item  i_in,
    output logic      o_busy,
    output logic      o_done,
    output t_out_item o_out
);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_done;
    t_out_item        r_out;
    t_out_item        n_out;

    logic      accept;
    logic      is_full;
    logic      is_empty;
    t_cell_ctl cell_ctl;

    t_entry cell_entry [QUEUE_DEPTH];
    logic   cell_keep  [QUEUE_DEPTH];
    logic   cell_occ   [QUEUE_DEPTH];

    assign o_busy   = 1'b0;
    assign accept   = i_start && !o_busy;
    assign is_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign is_empty = (r_count == '0);

    // Broadcast control to the chain.
    always_comb begin
        cell_ctl.do_insert        = accept && (i_in.opcode == OP_INSERT) && !is_full;
        cell_ctl.do_remove        = accept && (i_in.opcode == OP_REMOVE) && !is_empty;
        cell_ctl.new_entry.id     = i_in.job_id;
        cell_ctl.new_entry.key    = i_in.burst_time;
    end

    // The chain of cells; the head cell sees a left neighbor that always keeps,
    // so it takes the new entry whenever it does not keep its own.
    for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
        t_entry left_entry;
        logic   left_keep;
        t_entry right_entry;

        assign cell_occ[g] = (CNT_W'(g) < r_count);

        if (g == 0) begin : g_head
            assign left_entry = cell_ctl.new_entry;
            assign left_keep  = 1'b1;
        end else begin : g_body
            assign left_entry = cell_entry[g-1];
            assign left_keep  = cell_keep[g-1];
        end

        if (g == QUEUE_DEPTH - 1) begin : g_tail
            assign right_entry = '0;
        end else begin : g_inner
            assign right_entry = cell_entry[g+1];
        end

        sjrq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (cell_ctl),
            .i_occupied    (cell_occ[g]),
            .i_left_entry  (left_entry),
            .i_left_keep   (left_keep),
            .i_right_entry (right_entry),
            .o_entry       (cell_entry[g]),
            .o_keep        (cell_keep[g])
        );
    end

    // Next entry count.
    always_comb begin
        n_count = r_count;
        if (cell_ctl.do_insert) begin
            n_count = r_count + CNT_W'(1);
        end else if (cell_ctl.do_remove) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Result item: status and head job from the state before this item, occupancy from the count after it.
    always_comb begin
        n_out                = '0;
        n_out.occupancy      = OCC_W'(n_count);
        if (i_in.opcode == OP_INSERT) begin
            n_out.status = is_full ? ST_FULL : ST_OK;
        end else if (is_empty) begin
            n_out.status = ST_EMPTY;
        end else begin
            n_out.status         = ST_OK;
            n_out.out_valid      = 1'b1;
            n_out.out_job_id     = cell_entry[0].id;
            n_out.out_burst_time = cell_entry[0].key;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= accept;
        end
    end

    // Result payload register.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_done = r_done;
    assign o_out  = r_out;

    // The count never passes the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count above queue depth");

    // Every accepted item gives a result in the next cycle, and only then.
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_done)
        else $error("accepted item gave no result");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_done)
        else $error("result without an accepted item");

    // A returned job always carries ok status and lowers the count by one.
    a_remove_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cell_ctl.do_remove |=> (r_count == $past(r_count) - CNT_W'(1))
            && o_out.out_valid && (o_out.status == ST_OK))
        else $error("remove did not return the head job");

    // Refusals leave the count unchanged.
    a_refused_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && !cell_ctl.do_insert && !cell_ctl.do_remove) |=> $stable(r_count))
        else $error("refused item changed the entry count");

endmodule

@@ tb/tb_shortest_job_ready_queue_core.sv @@
// Self-checking testbench for shortest_job_ready_queue_core: a queue model predicts each result.
// Inserts and removes are driven with random gaps. Depends on sjrq_pkg and the core RTL.
// Results are compared field by field in order, and a watchdog ends a stalled run.

// Tracks the held jobs in burst-time order and queues the result each item should give.
class sjf_queue_checker;
    sjrq_pkg::t_entry    held[sjrq_pkg::QUEUE_DEPTH];
    int                  held_count;
    sjrq_pkg::t_out_item due_results[$];
    int                  errors;

    function new();
        held_count = 0;
        errors     = 0;
    endfunction

    // Apply one accepted item to the queue and record the result it must produce.
    function void apply_item(sjrq_pkg::t_in_item it);
        sjrq_pkg::t_out_item res;
        int                  pos;
        int                  i;
        res = '0;
        if (it.opcode == sjrq_pkg::OP_INSERT) begin
            if (held_count >= sjrq_pkg::QUEUE_DEPTH) begin
                res.status = sjrq_pkg::ST_FULL;
            end else begin
                // The new job goes behind every job whose key is not larger.
                pos = 0;
                while (pos < held_count && held[pos].key <= it.burst_time) pos++;
                for (i = held_count; i > pos; i--) held[i] = held[i-1];
                held[pos].id  = it.job_id;
                held[pos].key = it.burst_time;
                held_count++;
                res.status = sjrq_pkg::ST_OK;
            end
        end else begin
            if (held_count == 0) begin
                res.status = sjrq_pkg::ST_EMPTY;
            end else begin
                res.out_valid      = 1'b1;
                res.out_job_id     = held[0].id;
                res.out_burst_time = held[0].key;
                res.status         = sjrq_pkg::ST_OK;
                for (i = 1; i < held_count; i++) held[i-1] = held[i];
                held_count--;
            end
        end
        res.occupancy = sjrq_pkg::OCC_W'(held_count);
        due_results.push_back(res);
    endfunction

    // Compare one result with the oldest expected result.
    function void compare_result(sjrq_pkg::t_out_item got);
        sjrq_pkg::t_out_item exp;
        if (due_results.size() == 0) begin
            $error("result arrived with no item outstanding");
            errors++;
            return;
        end
        exp = due_results.pop_front();
        if (got.out_valid !== exp.out_valid) begin
            $error("out_valid: expected %0d, got %0d", exp.out_valid, got.out_valid);
            errors++;
        end
        if (got.out_job_id !== exp.out_job_id) begin
            $error("out_job_id: expected %0d, got %0d", exp.out_job_id, got.out_job_id);
            errors++;
        end
        if (got.out_burst_time !== exp.out_burst_time) begin
            $error("out_burst_time: expected %0d, got %0d",
                   exp.out_burst_time, got.out_burst_time);
            errors++;
        end
        if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status);
            errors++;
        end
        if (got.occupancy !== exp.occupancy) begin
            $error("occupancy: expected %0d, got %0d", exp.occupancy, got.occupancy);
            errors++;
        end
    endfunction
endclass

module tb_shortest_job_ready_queue_core;
    import sjrq_pkg::*;

    localparam int IDLE_LIMIT   = 64;
    localparam int RANDOM_ITEMS = 550;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      i_start;
    t_in_item  i_in;
    logic      o_busy;
    logic      o_done;
    t_out_item o_out;

    sjf_queue_checker sb;
    int               idle_cycles = 0;

    shortest_job_ready_queue_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_in    (i_in),
        .o_busy  (o_busy),
        .o_done  (o_done),
        .o_out   (o_out)
    );

    always #5 i_clk = ~i_clk;

    // Build one input item.
    function automatic t_in_item job(logic op, logic [ID_W-1:0] id, logic [KEY_W-1:0] key);
        t_in_item it;
        it.opcode     = op;
        it.job_id     = id;
        it.burst_time = key;
        return it;
    endfunction

    // Present one item after a random gap and return at the edge that accepts it.
    task automatic send_item(t_in_item it);
        int gap;
        gap = $urandom_range(0, 6);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_in    <= it;
        @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Watch both sides of the block at every rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_start && !o_busy) sb.apply_item(i_in);
            if (o_done !== 1'b0) sb.compare_result(o_out);
            if ((i_start && !o_busy) || o_done) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // End the run when nothing moves for too long.
    initial begin
        @(posedge i_rst_n);
        while (idle_cycles < IDLE_LIMIT) @(negedge i_clk);
        $display("Mismatches found");
        $finish;
    end

    // Reset, directed items, random phases, then drain.
    initial begin
        int       phase_len;
        int       insert_pct;
        int       key_mode;
        int       sent;
        int       k;
        t_in_item it;

        sb = new();
        i_rst_n <= 1'b0;
        i_start <= 1'b0;
        i_in    <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Remove from an empty queue, with all ones in the ignored fields.
        send_item(job(OP_REMOVE, 16'hFFFF, 16'hFFFF));

        // Fill the queue with extreme keys and ties, then push past full.
        send_item(job(OP_INSERT, 16'hFFFF, 16'hFFFF));
        send_item(job(OP_INSERT, 16'h0000, 16'h0000));
        send_item(job(OP_INSERT, 16'h1234, 16'h8000));
        send_item(job(OP_INSERT, 16'hAAAA, 16'h8000));
        send_item(job(OP_INSERT, 16'h5555, 16'h0000));
        send_item(job(OP_INSERT, 16'h0001, 16'hFFFF));
        for (k = 0; k < 10; k++) begin
            send_item(job(OP_INSERT, 16'(16'h0100 + k), 16'($urandom_range(0, 3))));
        end
        send_item(job(OP_INSERT, 16'h7777, 16'h0000));
        send_item(job(OP_INSERT, 16'hFFFF, 16'hFFFF));

        // Take the smallest jobs back out.
        for (k = 0; k < 6; k++) begin
            send_item(job(OP_REMOVE, 16'($urandom), 16'($urandom)));
        end

        // Random phases lean toward filling, draining or balance, with varied key spread.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0: begin
                    insert_pct = 80;
                end
                1: begin
                    insert_pct = 20;
                end
                default: begin
                    insert_pct = 50;
                end
            endcase
            key_mode = $urandom_range(0, 2);
            for (k = 0; k < phase_len && sent < RANDOM_ITEMS; k++) begin
                it.job_id = 16'($urandom);
                case (key_mode)
                    0: begin
                        it.burst_time = 16'($urandom);
                    end
                    1: begin
                        it.burst_time = 16'($urandom_range(0, 3));
                    end
                    default: begin
                        it.burst_time = $urandom_range(0, 1) ? 16'hFFFF
                                        : 16'($urandom_range(0, 1));
                    end
                endcase
                it.opcode = ($urandom_range(1, 100) <= insert_pct) ? OP_INSERT : OP_REMOVE;
                send_item(it);
                sent++;
            end
        end
        i_start <= 1'b0;

        // Let the last results arrive, then a few quiet cycles.
        while (sb.due_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (sb.errors == 0 && sb.due_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule
